// ===== src/sacmc_pkg.sv =====
// Shared types, constants and helper functions for the miss classifier.
package sacmc_pkg;

    // Configuration register indexes
    localparam logic [1:0] REG_OFFSET_BITS   = 2'd0;
    localparam logic [1:0] REG_INDEX_BITS    = 2'd1;
    localparam logic [1:0] REG_WAYS_IN_USE   = 2'd2;
    localparam logic [1:0] REG_RANDOM_POLICY = 2'd3;

    localparam int CFG_DATA_W = 5;

    localparam logic [4:0] RST_OFFSET_BITS   = 5'd2;
    localparam logic [3:0] RST_INDEX_BITS    = 4'd8;
    localparam logic [3:0] RST_WAYS_IN_USE   = 4'd1;
    localparam logic       RST_RANDOM_POLICY = 1'b1;

    // Miss classes
    localparam logic [1:0] CLS_HIT        = 2'd0;
    localparam logic [1:0] CLS_COMPULSORY = 2'd1;
    localparam logic [1:0] CLS_CONFLICT   = 2'd2;
    localparam logic [1:0] CLS_CAPACITY   = 2'd3;

    localparam logic [15:0] LFSR_SEED = 16'hACE1;
    localparam logic [15:0] LFSR_MASK = 16'hB400;

    // Effective geometry seen by the back end
    typedef struct packed {
        logic [4:0] offset_bits;
        logic [3:0] index_bits;
        logic [3:0] ways;
        logic       random_policy;
    } cfg_t;

    typedef struct packed {
        logic        was_hit;
        logic [1:0]  miss_class;
        logic [2:0]  way_used;
        logic [31:0] hit_total;
        logic [31:0] miss_total;
        logic [31:0] compulsory_total;
        logic [31:0] conflict_total;
        logic [31:0] capacity_total;
    } result_t;

    typedef enum logic [1:0] {
        ST_IDLE  = 2'b01,
        ST_CHECK = 2'b10
    } back_state_t;

    function automatic logic [15:0] lfsr_step(input logic [15:0] v);
        logic [15:0] n;
        n = v >> 1;
        if (v[0])
        begin
            n = n ^ LFSR_MASK;
        end
        return n;
    endfunction

    // Eight restoring steps of a remainder by a small divisor, one byte at a time
    function automatic logic [3:0] mod_byte(input logic [3:0] r_in, input logic [7:0] b,
                                            input logic [3:0] d);
        logic [4:0] t;
        logic [3:0] r;
        r = r_in;
        for (int i = 7; i >= 0; i--)
        begin
            t = {r, b[i]};
            if (t >= {1'b0, d})
            begin
                t = t - {1'b0, d};
            end
            r = t[3:0];
        end
        return r;
    endfunction

    function automatic logic [31:0] sat_inc(input logic [31:0] v);
        return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
    endfunction

endpackage

// ===== src/set_assoc_cache_miss_classifier.sv =====
// Top level of the set-associative cache miss classifier.
//
//  channel   handshake          payload
//  -------   ---------          -------
//  input     push / full        address
//  result    pop / empty        was_hit, miss_class, way_used, five running totals
//  config    cfg_we             cfg_index, cfg_data
//
// In the back end, a transaction first reads the set row from the tag RAM, then in the
// check state compares the ways, writes the row back and queues the result.
// Reset clears per-set row flags at once, so no clearing pass is needed.
// A two-entry queue on each side lets input and result stall independently;
// the back end starts a lookup only while the result queue has room.
module set_assoc_cache_miss_classifier #(
    parameter int MAX_SETS  = 256,
    parameter int MAX_WAYS  = 8,
    parameter int ADDR_BITS = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [31:0] address,
    output logic        empty,
    input  logic        pop,
    output logic        was_hit,
    output logic [1:0]  miss_class,
    output logic [2:0]  way_used,
    output logic [31:0] hit_total,
    output logic [31:0] miss_total,
    output logic [31:0] compulsory_total,
    output logic [31:0] conflict_total,
    output logic [31:0] capacity_total,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [sacmc_pkg::CFG_DATA_W-1:0] cfg_data
);

    localparam int SET_W = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
    localparam int Q_W   = SET_W + ADDR_BITS;
    localparam int RES_W = $bits(sacmc_pkg::result_t);

    sacmc_pkg::cfg_t      cfg;
    sacmc_pkg::result_t   res_in, res_out;
    logic                 flush;
    logic [SET_W-1:0]     f_set, q_set;
    logic [ADDR_BITS-1:0] f_tag, q_tag;
    logic                 q_empty, q_pop;
    logic                 res_full, res_push;
    logic [RES_W-1:0]     res_rdata;

    sacmc_front #(
        .MAX_SETS (MAX_SETS),
        .MAX_WAYS (MAX_WAYS),
        .ADDR_BITS(ADDR_BITS)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .address  (address),
        .set_idx  (f_set),
        .tag      (f_tag),
        .cfg      (cfg),
        .flush    (flush)
    );

    sacmc_fifo #(
        .WIDTH(Q_W),
        .DEPTH(2)
    ) u_req_q (
        .clk  (clk),
        .rst_n(rst_n),
        .push (push),
        .wdata({f_set, f_tag}),
        .full (full),
        .pop  (q_pop),
        .rdata({q_set, q_tag}),
        .empty(q_empty)
    );

    sacmc_back #(
        .MAX_SETS (MAX_SETS),
        .MAX_WAYS (MAX_WAYS),
        .ADDR_BITS(ADDR_BITS)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .flush   (flush),
        .q_empty (q_empty),
        .q_set   (q_set),
        .q_tag   (q_tag),
        .q_pop   (q_pop),
        .res_full(res_full),
        .res_push(res_push),
        .res     (res_in)
    );

    sacmc_fifo #(
        .WIDTH(RES_W),
        .DEPTH(2)
    ) u_res_q (
        .clk  (clk),
        .rst_n(rst_n),
        .push (res_push),
        .wdata(res_in),
        .full (res_full),
        .pop  (pop),
        .rdata(res_rdata),
        .empty(empty)
    );

    assign res_out          = sacmc_pkg::result_t'(res_rdata);
    assign was_hit          = res_out.was_hit;
    assign miss_class       = res_out.miss_class;
    assign way_used         = res_out.way_used;
    assign hit_total        = res_out.hit_total;
    assign miss_total       = res_out.miss_total;
    assign compulsory_total = res_out.compulsory_total;
    assign conflict_total   = res_out.conflict_total;
    assign capacity_total   = res_out.capacity_total;

endmodule

// ===== src/sacmc_ram.sv =====
// Generic single-port-write, registered-read RAM.
module sacmc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                  clk,
    input  logic                                  we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                      wdata,
    input  logic                                  re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== src/sacmc_fifo.sv =====
// Small synchronous queue with push/full and pop/empty.
module sacmc_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

// ===== src/sacmc_front.sv =====
// Front end: configuration registers and address split into set index and tag.
module sacmc_front #(
    parameter int MAX_SETS  = 256,
    parameter int MAX_WAYS  = 8,
    parameter int ADDR_BITS = 32
) (
    input  logic                                         clk,
    input  logic                                         rst_n,
    input  logic                                         cfg_we,
    input  logic [1:0]                                   cfg_index,
    input  logic [sacmc_pkg::CFG_DATA_W-1:0]             cfg_data,
    input  logic [31:0]                                  address,
    output logic [(MAX_SETS > 1 ? $clog2(MAX_SETS) : 1)-1:0] set_idx,
    output logic [ADDR_BITS-1:0]                         tag,
    output sacmc_pkg::cfg_t                              cfg,
    output logic                                         flush
);

    localparam int SET_W  = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
    localparam int MAX_IB = $clog2(MAX_SETS + 1) - 1;

    logic [4:0] offset_bits_reg;
    logic [3:0] index_bits_reg;
    logic [3:0] ways_in_use_reg;
    logic       random_policy_reg;

    logic [ADDR_BITS-1:0] block;
    logic [SET_W-1:0]     set_mask;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_bits_reg   <= sacmc_pkg::RST_OFFSET_BITS;
            index_bits_reg    <= sacmc_pkg::RST_INDEX_BITS;
            ways_in_use_reg   <= sacmc_pkg::RST_WAYS_IN_USE;
            random_policy_reg <= sacmc_pkg::RST_RANDOM_POLICY;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                sacmc_pkg::REG_OFFSET_BITS:   offset_bits_reg   <= cfg_data[4:0];
                sacmc_pkg::REG_INDEX_BITS:    index_bits_reg    <= cfg_data[3:0];
                sacmc_pkg::REG_WAYS_IN_USE:   ways_in_use_reg   <= cfg_data[3:0];
                sacmc_pkg::REG_RANDOM_POLICY: random_policy_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // Any geometry write drops every line
    assign flush = cfg_we && (cfg_index == sacmc_pkg::REG_OFFSET_BITS ||
                              cfg_index == sacmc_pkg::REG_INDEX_BITS ||
                              cfg_index == sacmc_pkg::REG_WAYS_IN_USE);

    always_comb
    begin
        cfg.offset_bits   = offset_bits_reg;
        cfg.index_bits    = (index_bits_reg > 4'(MAX_IB)) ? 4'(MAX_IB) : index_bits_reg;
        if (ways_in_use_reg == 4'd0)
        begin
            cfg.ways = 4'd1;
        end
        else if ({1'b0, ways_in_use_reg} > 5'(MAX_WAYS))
        begin
            cfg.ways = 4'(MAX_WAYS);
        end
        else
        begin
            cfg.ways = ways_in_use_reg;
        end
        cfg.random_policy = random_policy_reg;
    end

    assign block    = address[ADDR_BITS-1:0] >> offset_bits_reg;
    assign set_mask = ~({SET_W{1'b1}} << cfg.index_bits);
    assign set_idx  = SET_W'(block) & set_mask;
    assign tag      = block >> cfg.index_bits;

endmodule

// ===== src/sacmc_back.sv =====
// Back end: set lookup, fill or eviction, miss classification and running totals.
module sacmc_back #(
    parameter int MAX_SETS  = 256,
    parameter int MAX_WAYS  = 8,
    parameter int ADDR_BITS = 32
) (
    input  logic                                         clk,
    input  logic                                         rst_n,
    input  sacmc_pkg::cfg_t                              cfg,
    input  logic                                         flush,
    input  logic                                         q_empty,
    input  logic [(MAX_SETS > 1 ? $clog2(MAX_SETS) : 1)-1:0] q_set,
    input  logic [ADDR_BITS-1:0]                         q_tag,
    output logic                                         q_pop,
    input  logic                                         res_full,
    output logic                                         res_push,
    output sacmc_pkg::result_t                           res
);

    localparam int SET_W  = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
    localparam int WAY_W  = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam int MAX_IB = $clog2(MAX_SETS + 1) - 1;
    localparam int ENT_W  = ADDR_BITS + 1;
    localparam int ROW_W  = MAX_WAYS * ENT_W;
    localparam int CNT_W  = $clog2(MAX_SETS * MAX_WAYS + 1);
    localparam int LIU_W  = 4 + MAX_IB;
    localparam int CMP_W  = (CNT_W > LIU_W) ? CNT_W : LIU_W;

    sacmc_pkg::back_state_t state_reg, state_next;

    logic [SET_W-1:0]     set_reg;
    logic [ADDR_BITS-1:0] tag_reg;
    logic [3:0]           rem_hi_reg;
    logic [MAX_SETS-1:0]  row_ok_reg;
    logic [CNT_W-1:0]     line_count_reg;
    logic [15:0]          lfsr_reg;
    logic [31:0]          hit_cnt_reg, miss_cnt_reg, comp_cnt_reg, conf_cnt_reg, cap_cnt_reg;

    logic                 start;
    logic                 check;
    logic [ROW_W-1:0]     row_q;
    logic [ROW_W-1:0]     row_new;
    logic [MAX_WAYS-1:0]  way_valid;
    logic [MAX_WAYS-1:0]  way_match;
    logic [MAX_WAYS-1:0]  way_free;
    logic                 any_hit, any_free;
    logic [WAY_W-1:0]     hit_way, free_way, way_sel;
    logic [15:0]          lfsr_nx;
    logic [3:0]           rem;
    logic [LIU_W-1:0]     lines_in_use;
    logic                 full_cache;
    logic [1:0]           cls;
    logic                 do_write;
    logic                 evict_rand;

    assign start = (state_reg == sacmc_pkg::ST_IDLE) && !q_empty && !res_full;
    assign check = (state_reg == sacmc_pkg::ST_CHECK);
    assign q_pop = start;

    sacmc_ram #(
        .WIDTH(ROW_W),
        .DEPTH(MAX_SETS)
    ) u_row_ram (
        .clk  (clk),
        .we   (do_write),
        .waddr(set_reg),
        .wdata(row_new),
        .re   (start),
        .raddr(q_set),
        .rdata(row_q)
    );

    always_comb
    begin
        for (int w = 0; w < MAX_WAYS; w++)
        begin
            way_valid[w] = row_q[w * ENT_W + ADDR_BITS] && row_ok_reg[set_reg];
            way_match[w] = way_valid[w] && (row_q[w * ENT_W +: ADDR_BITS] == tag_reg)
                           && (5'(w) < {1'b0, cfg.ways});
            way_free[w]  = !way_valid[w] && (5'(w) < {1'b0, cfg.ways});
        end
        any_hit  = |way_match;
        any_free = |way_free;
        hit_way  = '0;
        free_way = '0;
        // lowest way wins
        for (int w = MAX_WAYS - 1; w >= 0; w--)
        begin
            if (way_match[w])
            begin
                hit_way = WAY_W'(w);
            end
            if (way_free[w])
            begin
                free_way = WAY_W'(w);
            end
        end
    end

    assign lfsr_nx      = sacmc_pkg::lfsr_step(lfsr_reg);
    assign rem          = sacmc_pkg::mod_byte(rem_hi_reg, lfsr_nx[7:0], cfg.ways);
    assign lines_in_use = LIU_W'(cfg.ways) << cfg.index_bits;
    assign full_cache   = CMP_W'(line_count_reg) >= CMP_W'(lines_in_use);
    assign evict_rand   = check && !any_hit && !any_free && cfg.random_policy;
    assign do_write     = check && !any_hit;

    always_comb
    begin
        if (any_hit)
        begin
            cls     = sacmc_pkg::CLS_HIT;
            way_sel = hit_way;
        end
        else if (any_free)
        begin
            cls     = sacmc_pkg::CLS_COMPULSORY;
            way_sel = free_way;
        end
        else
        begin
            cls     = full_cache ? sacmc_pkg::CLS_CAPACITY : sacmc_pkg::CLS_CONFLICT;
            way_sel = cfg.random_policy ? WAY_W'(rem) : '0;
        end
    end

    // Read-modify-write of the whole set row; stale valid bits drop if the row flag is clear
    always_comb
    begin
        row_new = row_q;
        for (int w = 0; w < MAX_WAYS; w++)
        begin
            row_new[w * ENT_W + ADDR_BITS] = way_valid[w];
        end
        row_new[way_sel * ENT_W +: ENT_W] = {1'b1, tag_reg};
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            sacmc_pkg::ST_IDLE:  if (start) state_next = sacmc_pkg::ST_CHECK;
            sacmc_pkg::ST_CHECK: state_next = sacmc_pkg::ST_IDLE;
            default:             state_next = sacmc_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        res.was_hit          = any_hit;
        res.miss_class       = cls;
        res.way_used         = 3'(way_sel);
        res.hit_total        = any_hit ? sacmc_pkg::sat_inc(hit_cnt_reg) : hit_cnt_reg;
        res.miss_total       = any_hit ? miss_cnt_reg : sacmc_pkg::sat_inc(miss_cnt_reg);
        res.compulsory_total = (cls == sacmc_pkg::CLS_COMPULSORY) ?
                               sacmc_pkg::sat_inc(comp_cnt_reg) : comp_cnt_reg;
        res.conflict_total   = (cls == sacmc_pkg::CLS_CONFLICT) ?
                               sacmc_pkg::sat_inc(conf_cnt_reg) : conf_cnt_reg;
        res.capacity_total   = (cls == sacmc_pkg::CLS_CAPACITY) ?
                               sacmc_pkg::sat_inc(cap_cnt_reg) : cap_cnt_reg;
    end

    assign res_push = check;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= sacmc_pkg::ST_IDLE;
            row_ok_reg     <= '0;
            line_count_reg <= '0;
            lfsr_reg       <= sacmc_pkg::LFSR_SEED;
            hit_cnt_reg    <= '0;
            miss_cnt_reg   <= '0;
            comp_cnt_reg   <= '0;
            conf_cnt_reg   <= '0;
            cap_cnt_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (flush)
            begin
                row_ok_reg     <= '0;
                line_count_reg <= '0;
            end
            else if (do_write)
            begin
                row_ok_reg[set_reg] <= 1'b1;
                if (cls == sacmc_pkg::CLS_COMPULSORY)
                begin
                    line_count_reg <= line_count_reg + 1'b1;
                end
            end
            if (evict_rand)
            begin
                lfsr_reg <= lfsr_nx;
            end
            if (check)
            begin
                hit_cnt_reg  <= res.hit_total;
                miss_cnt_reg <= res.miss_total;
                comp_cnt_reg <= res.compulsory_total;
                conf_cnt_reg <= res.conflict_total;
                cap_cnt_reg  <= res.capacity_total;
            end
        end
    end

    // Upper byte of the victim remainder is worked out while the row is read
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            set_reg    <= q_set;
            tag_reg    <= q_tag;
            rem_hi_reg <= sacmc_pkg::mod_byte(4'd0, lfsr_nx[15:8], cfg.ways);
        end
    end

endmodule
